@@ hdl/lrs_pkg.sv @@
// Shared types, codes and widths for the line raster stepper.
package lrs_pkg;

    localparam int COORD_BITS   = 10;
    localparam int ERR_BITS     = COORD_BITS + 1;
    localparam int COLOR_BITS   = 16;
    localparam int CFG_IDX_BITS = 1;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_NEXT  = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FG_COLOR = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BG_COLOR = 1'b1;

    localparam logic [1:0] DIR_ZERO = 2'd0;
    localparam logic [1:0] DIR_POS  = 2'd1;
    localparam logic [1:0] DIR_NEG  = 2'd3;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [ERR_BITS-1:0]   t_err;
    typedef logic [COLOR_BITS-1:0] t_color;
    typedef logic [1:0]            t_dir;

    typedef struct packed {
        logic   action;
        t_coord x_start;
        t_coord y_start;
        t_coord x_end;
        t_coord y_end;
        logic   erase;
    } t_in_word;

    typedef struct packed {
        t_coord pix_x;
        t_coord pix_y;
        t_color pix_color;
        logic   last;
    } t_out_word;

    typedef struct packed {
        t_coord cur_col;
        t_coord cur_row;
        t_err   err_col;
        t_err   err_row;
        t_coord abs_dx;
        t_coord abs_dy;
        t_coord major_len;
        t_dir   dir_col;
        t_dir   dir_row;
        t_err   pixels_left;
        logic   line_active;
        t_color line_color;
    } t_line_state;

    typedef struct packed {
        logic      emit;
        t_out_word word;
    } t_step_result;

endpackage

@@ hdl/line_raster_stepper.sv @@
// Top level of the line raster stepper: config registers and pixel output register.
// One input word is taken per clock while o_in_ready is high; each start or active
// next word yields one registered pixel word. Sustained rate is one pixel per clock,
// limited only by the output register, which accepts a new word in the cycle its held
// word is taken. A start word emits the first pixel of a line of max(|dx|,|dy|)+1
// pixels; each next word emits one more, with last set on the final one, and a next
// word with no line in progress gives no pixel. Color registers are sampled at start.
module line_raster_stepper (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  lrs_pkg::t_in_word                i_in_word,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output lrs_pkg::t_out_word               o_out_word,
    input  logic                             i_cfg_we,
    input  logic [lrs_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [lrs_pkg::COLOR_BITS-1:0]   i_cfg_data
);
    import lrs_pkg::*;

    t_color       r_fg_color;
    t_color       r_bg_color;
    logic         r_out_valid;
    t_out_word    r_out_word;
    logic         in_accept;
    t_step_result step_res;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    lrs_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_word     (i_in_word),
        .i_fg_color (r_fg_color),
        .i_bg_color (r_bg_color),
        .o_result   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg_color <= '0;
            r_bg_color <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FG_COLOR: r_fg_color <= i_cfg_data;
                CFG_BG_COLOR: r_bg_color <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && step_res.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && step_res.emit) begin
            r_out_word <= step_res.word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ hdl/lrs_step.sv @@
// Line state registers and the per-word pixel stepping logic.
module lrs_step (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  lrs_pkg::t_in_word     i_word,
    input  lrs_pkg::t_color       i_fg_color,
    input  lrs_pkg::t_color       i_bg_color,
    output lrs_pkg::t_step_result o_result
);
    import lrs_pkg::*;

    t_line_state r_state;
    t_line_state n_state;
    t_line_state s_cur;
    logic        start;
    logic        emit;
    t_err        sum_col;
    t_err        sum_row;
    t_err        major_ext;

    function automatic t_coord axis_mag(input t_coord a, input t_coord b);
        if (b > a) begin
            return b - a;
        end else begin
            return a - b;
        end
    endfunction

    function automatic t_dir axis_dir(input t_coord a, input t_coord b);
        if (b > a) begin
            return DIR_POS;
        end else if (b == a) begin
            return DIR_ZERO;
        end else begin
            return DIR_NEG;
        end
    endfunction

    function automatic t_coord step_coord(input t_coord c, input t_dir d);
        case (d)
            DIR_POS: return c + t_coord'(1);
            DIR_NEG: return c - t_coord'(1);
            default: return c;
        endcase
    endfunction

    assign start = (i_word.action == ACT_START);
    assign emit  = start || r_state.line_active;

    // state the emitted pixel is taken from: fresh setup on start
    always_comb begin
        s_cur = r_state;
        if (start) begin
            s_cur.cur_col     = i_word.x_start;
            s_cur.cur_row     = i_word.y_start;
            s_cur.err_col     = '0;
            s_cur.err_row     = '0;
            s_cur.abs_dx      = axis_mag(i_word.x_start, i_word.x_end);
            s_cur.abs_dy      = axis_mag(i_word.y_start, i_word.y_end);
            s_cur.dir_col     = axis_dir(i_word.x_start, i_word.x_end);
            s_cur.dir_row     = axis_dir(i_word.y_start, i_word.y_end);
            s_cur.major_len   = (s_cur.abs_dx > s_cur.abs_dy) ? s_cur.abs_dx : s_cur.abs_dy;
            s_cur.pixels_left = {1'b0, s_cur.major_len} + t_err'(1);
            s_cur.line_color  = i_word.erase ? i_bg_color : i_fg_color;
            s_cur.line_active = 1'b1;
        end
    end

    assign major_ext = {1'b0, s_cur.major_len};
    assign sum_col   = s_cur.err_col + {1'b0, s_cur.abs_dx};
    assign sum_row   = s_cur.err_row + {1'b0, s_cur.abs_dy};

    always_comb begin
        n_state         = s_cur;
        n_state.err_col = sum_col;
        n_state.err_row = sum_row;
        if (sum_col > major_ext) begin
            n_state.err_col = sum_col - major_ext;
            n_state.cur_col = step_coord(s_cur.cur_col, s_cur.dir_col);
        end
        if (sum_row > major_ext) begin
            n_state.err_row = sum_row - major_ext;
            n_state.cur_row = step_coord(s_cur.cur_row, s_cur.dir_row);
        end
        if (s_cur.pixels_left != '0) begin
            n_state.pixels_left = s_cur.pixels_left - t_err'(1);
        end
        n_state.line_active = (n_state.pixels_left != '0);
    end

    always_comb begin
        o_result.emit           = emit;
        o_result.word.pix_x     = s_cur.cur_col;
        o_result.word.pix_y     = s_cur.cur_row;
        o_result.word.pix_color = s_cur.line_color;
        o_result.word.last      = (s_cur.pixels_left == t_err'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_accept && emit) begin
            r_state <= n_state;
        end
    end

endmodule

@@ hdl/lrs_checker.sv @@
// Port-level assertions for the line raster stepper, bound to the top level.
module lrs_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input lrs_pkg::t_in_word                i_in_word,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input lrs_pkg::t_out_word               o_out_word
);
    import lrs_pkg::*;

    logic start_acc;
    assign start_acc = i_in_valid && o_in_ready && (i_in_word.action == ACT_START);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_word))
        else $error("output word changed while stalled");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

    a_start_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start_acc |=> o_out_valid && (o_out_word.pix_x == $past(i_in_word.x_start))
                      && (o_out_word.pix_y == $past(i_in_word.y_start)))
        else $error("start word did not emit its first pixel");

    a_point_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start_acc && (i_in_word.x_start == i_in_word.x_end)
                  && (i_in_word.y_start == i_in_word.y_end) |=> o_out_word.last)
        else $error("single-pixel line not marked last");

endmodule

bind line_raster_stepper lrs_checker u_lrs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

@@ sim/line_raster_stepper_test.sv @@
// Self-checking testbench for line_raster_stepper: directed and random line sequences checked by a scoreboard.
module line_raster_stepper_test;
    import lrs_pkg::*;

    localparam int ITEM_TARGET = 900;
    localparam int PHASE_ITEMS = 150;
    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT = 400000;

    class pixel_scoreboard;
        t_line_state st;
        t_color fg_color;
        t_color bg_color;
        t_out_word expected_pixels[$];
        int mismatches;

        function new();
            st = '0;
            fg_color = '0;
            bg_color = '0;
            mismatches = 0;
        endfunction

        function void set_colors(t_color p, t_color b);
            fg_color = p;
            bg_color = b;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function t_coord advance(t_coord c, t_dir d);
            if (d == DIR_POS) return c + 1'b1;
            if (d == DIR_NEG) return c - 1'b1;
            return c;
        endfunction

        function void set_axis(input t_coord a, input t_coord b,
                               output t_coord mag, output t_dir dir);
            if (b > a) begin
                mag = b - a;
                dir = DIR_POS;
            end else if (b == a) begin
                mag = '0;
                dir = DIR_ZERO;
            end else begin
                mag = a - b;
                dir = DIR_NEG;
            end
        endfunction

        // returns 1 when the word yields a pixel
        function bit note_word(t_in_word w);
            t_out_word px;
            t_coord mag;
            t_dir dir;
            if (w.action == ACT_START) begin
                set_axis(w.x_start, w.x_end, mag, dir);
                st.abs_dx = mag;
                st.dir_col = dir;
                set_axis(w.y_start, w.y_end, mag, dir);
                st.abs_dy = mag;
                st.dir_row = dir;
                st.major_len = (st.abs_dx > st.abs_dy) ? st.abs_dx : st.abs_dy;
                st.cur_col = w.x_start;
                st.cur_row = w.y_start;
                st.err_col = '0;
                st.err_row = '0;
                st.pixels_left = t_err'(st.major_len) + 1'b1;
                st.line_color = w.erase ? bg_color : fg_color;
                st.line_active = 1'b1;
            end else if (!st.line_active) begin
                return 1'b0;
            end
            px.pix_x = st.cur_col;
            px.pix_y = st.cur_row;
            px.pix_color = st.line_color;
            px.last = (st.pixels_left == t_err'(1));
            expected_pixels.push_back(px);
            st.err_col = st.err_col + t_err'(st.abs_dx);
            st.err_row = st.err_row + t_err'(st.abs_dy);
            if (st.err_col > t_err'(st.major_len)) begin
                st.err_col = st.err_col - t_err'(st.major_len);
                st.cur_col = advance(st.cur_col, st.dir_col);
            end
            if (st.err_row > t_err'(st.major_len)) begin
                st.err_row = st.err_row - t_err'(st.major_len);
                st.cur_row = advance(st.cur_row, st.dir_row);
            end
            if (st.pixels_left != '0) st.pixels_left = st.pixels_left - 1'b1;
            st.line_active = (st.pixels_left != '0);
            return 1'b1;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_pixel(t_out_word got);
            t_out_word want;
            if (expected_pixels.size() == 0) begin
                report($sformatf("pixel (%0d,%0d) with none pending", got.pix_x, got.pix_y));
                return;
            end
            want = expected_pixels.pop_front();
            if (got.pix_x !== want.pix_x)
                report($sformatf("pix_x got %0d expected %0d", got.pix_x, want.pix_x));
            if (got.pix_y !== want.pix_y)
                report($sformatf("pix_y got %0d expected %0d", got.pix_y, want.pix_y));
            if (got.pix_color !== want.pix_color)
                report($sformatf("pix_color got %h expected %h", got.pix_color, want.pix_color));
            if (got.last !== want.last)
                report($sformatf("last got %b expected %b", got.last, want.last));
        endtask
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    t_in_word                i_in_word;
    logic                    o_out_valid;
    logic                    i_out_ready;
    t_out_word               o_out_word;
    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [COLOR_BITS-1:0]   i_cfg_data;

    pixel_scoreboard sb = new();
    int pixel_words_sent = 0;
    int cycles = 0;
    bit calm = 1'b0;

    line_raster_stepper uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 10);
    endfunction

    function automatic int span(t_coord a, t_coord b);
        return (a > b) ? int'(a - b) : int'(b - a);
    endfunction

    function automatic t_color draw_color();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return t_color'($urandom);
        endcase
    endfunction

    // pixel sink: random stalls between words
    initial begin
        int stall;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_pixel(o_out_word);
            @(negedge i_clk);
        end
    end

    task automatic drive_word(t_in_word w);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (!o_in_ready);
        if (sb.note_word(w)) pixel_words_sent++;
        @(negedge i_clk);
    endtask

    task automatic start_line(t_coord xs, t_coord ys, t_coord xe, t_coord ye, logic erase);
        t_in_word w;
        w.action = ACT_START;
        w.x_start = xs;
        w.y_start = ys;
        w.x_end = xe;
        w.y_end = ye;
        w.erase = erase;
        drive_word(w);
    endtask

    // fields other than action carry noise on a next word
    task automatic next_pixel();
        t_in_word w;
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        w = noise[$bits(t_in_word)-1:0];
        w.action = ACT_NEXT;
        drive_word(w);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_colors(t_color p, t_color b);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_FG_COLOR;
        i_cfg_data <= p;
        @(negedge i_clk);
        i_cfg_idx <= CFG_BG_COLOR;
        i_cfg_data <= b;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_colors(p, b);
    endtask

    initial begin
        int phase;
        int phase_mark;
        int major;
        int n_next;
        t_coord xs, ys, xe, ye;

        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        write_colors(16'hFFFF, 16'h0000);

        // directed part
        next_pixel();
        start_line(10'd100, 10'd200, 10'd100, 10'd200, 1'b0);
        next_pixel();
        start_line(10'd0, 10'd1023, 10'd1023, 10'd0, 1'b1);
        repeat (3) next_pixel();
        start_line(10'd1023, 10'd0, 10'd0, 10'd1023, 1'b0);
        repeat (2) next_pixel();
        start_line(10'd5, 10'd5, 10'd8, 10'd6, 1'b0);
        repeat (4) next_pixel();
        start_line(10'd7, 10'd3, 10'd7, 10'd0, 1'b1);
        repeat (3) next_pixel();
        start_line(10'd40, 10'd9, 10'd30, 10'd9, 1'b0);
        repeat (3) next_pixel();
        wait_idle();
        write_colors(16'h0000, 16'hFFFF);
        repeat (7) next_pixel();
        start_line(10'd1023, 10'd1023, 10'd1020, 10'd1022, 1'b1);

        // random line sequences
        phase = 0;
        phase_mark = pixel_words_sent + PHASE_ITEMS;
        while (pixel_words_sent < ITEM_TARGET) begin
            xs = t_coord'($urandom);
            ys = t_coord'($urandom);
            if ($urandom_range(0, 15) == 0) begin
                xe = t_coord'($urandom);
                ye = t_coord'($urandom);
            end else begin
                xe = t_coord'(int'(xs) + $urandom_range(0, 24) - 12);
                ye = t_coord'(int'(ys) + $urandom_range(0, 24) - 12);
            end
            major = span(xs, xe) > span(ys, ye) ? span(xs, xe) : span(ys, ye);
            case ($urandom_range(0, 5))
                0: n_next = $urandom_range(0, major);
                1: n_next = major + $urandom_range(1, 3);
                default: n_next = major;
            endcase
            start_line(xs, ys, xe, ye, 1'($urandom_range(0, 1)));
            for (int i = 0; i < n_next; i++) begin
                next_pixel();
                if (pixel_words_sent >= phase_mark) begin
                    wait_idle();
                    write_colors(draw_color(), draw_color());
                    phase++;
                    calm = (phase % 3 == 2);
                    phase_mark += PHASE_ITEMS;
                end
            end
        end

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
